FILE: hw/rtl/pfb_pkg.sv
// Package for the page framebuffer blitter: field widths, item codes and the
// command/status structs between controller and datapath.
// No dependencies; compile first.
package pfb_pkg;

    // Fixed field widths of the request and response beats
    localparam int LEFT_X_W = 7;
    localparam int TOP_Y_W  = 6;
    localparam int ICOL_W   = 8;
    localparam int IPAGE_W  = 3;
    localparam int BYTE_W   = 8;
    localparam int RPAGE_W  = 3;
    localparam int RCOL_W   = 7;

    // Pixel rows per page and a full byte mask
    localparam logic [8:0]        PAGE_ROWS = 9'd8;
    localparam logic [BYTE_W-1:0] BYTE_MASK = 8'hFF;

    // Request mode codes
    typedef enum logic {
        MODE_BLIT = 1'b0,
        MODE_READ = 1'b1
    } mode_t;

    // Controller to datapath
    typedef struct packed {
        logic load;       // latch a request beat
        logic mem_rd;     // read the addressed byte
        logic mem_wr;     // write the merged byte back
        logic sel_lower;  // address the page below the target
        logic clr_step;   // write zero at the clear pointer
        logic out_load;   // capture the response payload
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_read;    // latched item is a read
        logic go_main;    // target byte is on screen (or read in range)
        logic go_lower;   // lower part lands in the next page
        logic clear_done; // clear pointer at last entry
    } dp_status_t;

endpackage

FILE: hw/rtl/pfb_if.sv
// Valid/ready channel interfaces for blitter requests and responses.
// Depends on pfb_pkg for the field widths.
interface pfb_req_if;
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic [pfb_pkg::LEFT_X_W-1:0]  left_x;
    logic [pfb_pkg::TOP_Y_W-1:0]   top_y;
    logic [pfb_pkg::ICOL_W-1:0]    image_column;
    logic [pfb_pkg::IPAGE_W-1:0]   image_page;
    logic [pfb_pkg::BYTE_W-1:0]    pixel_byte;
    logic [pfb_pkg::RPAGE_W-1:0]   read_page;
    logic [pfb_pkg::RCOL_W-1:0]    read_column;

    modport source (
        output valid, mode, left_x, top_y, image_column, image_page, pixel_byte,
               read_page, read_column,
        input  ready
    );
    modport sink (
        input  valid, mode, left_x, top_y, image_column, image_page, pixel_byte,
               read_page, read_column,
        output ready
    );
endinterface

interface pfb_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [pfb_pkg::BYTE_W-1:0]  read_data;
    logic                        written;
    logic                        clipped;

    modport source (
        output valid, read_data, written, clipped,
        input  ready
    );
    modport sink (
        input  valid, read_data, written, clipped,
        output ready
    );
endinterface

FILE: hw/rtl/pfb_ctrl.sv
// Blitter controller: sequences the clear pass, read-modify-write of up to
// two page bytes, and the response register handshake. Depends on pfb_pkg.
module pfb_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    input  pfb_pkg::dp_status_t status,
    output pfb_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD_UP,
        S_WR_UP,
        S_RD_LO,
        S_WR_LO,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // Next state and command decode
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg & ~rsp_ready;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clear_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_RD_UP;
                end
            end
            S_RD_UP:
            begin
                if (status.go_main)
                begin
                    cmd.mem_rd = 1'b1;
                    state_next = status.is_read ? S_FINISH : S_WR_UP;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_WR_UP:
            begin
                cmd.mem_wr = 1'b1;
                state_next = status.go_lower ? S_RD_LO : S_FINISH;
            end
            S_RD_LO:
            begin
                cmd.mem_rd    = 1'b1;
                cmd.sel_lower = 1'b1;
                state_next    = S_WR_LO;
            end
            S_WR_LO:
            begin
                cmd.mem_wr    = 1'b1;
                cmd.sel_lower = 1'b1;
                state_next    = S_FINISH;
            end
            S_FINISH:
            begin
                // wait for the response register to free up
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and response valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = out_valid_reg;

    // Single port: never read and write in one cycle
    a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.mem_rd && cmd.mem_wr) && !(cmd.clr_step && (cmd.mem_rd || cmd.mem_wr)))
        else $error("memory port used twice in one cycle");

    // Every write-back uses the byte read the cycle before
    a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mem_wr |-> $past(cmd.mem_rd))
        else $error("write-back without a preceding read");

    // Response register never overwritten while a beat waits
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || rsp_ready))
        else $error("pending response overwritten");

    // Lower page handled only right after the upper write-back
    a_lower_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD_LO) |-> $past(state_reg == S_WR_UP))
        else $error("lower page read out of order");

endmodule

FILE: hw/rtl/pfb_datapath.sv
// Blitter datapath: request latch, address and mask generation, the frame
// store memory with its clear pointer, and the response register.
// Depends on pfb_pkg.
module pfb_datapath #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64,
    parameter int PAGE_COUNT    = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  pfb_pkg::ctrl_cmd_t                 cmd,
    output pfb_pkg::dp_status_t                status,
    input  logic                               mode,
    input  logic [pfb_pkg::LEFT_X_W-1:0]       left_x,
    input  logic [pfb_pkg::TOP_Y_W-1:0]        top_y,
    input  logic [pfb_pkg::ICOL_W-1:0]         image_column,
    input  logic [pfb_pkg::IPAGE_W-1:0]        image_page,
    input  logic [pfb_pkg::BYTE_W-1:0]         pixel_byte,
    input  logic [pfb_pkg::RPAGE_W-1:0]        read_page,
    input  logic [pfb_pkg::RCOL_W-1:0]         read_column,
    output logic [pfb_pkg::BYTE_W-1:0]         read_data,
    output logic                               written,
    output logic                               clipped
);

    localparam int DEPTH  = PAGE_COUNT * SCREEN_WIDTH;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int AW1    = ADDR_W + 1;
    localparam int COL_W  = (SCREEN_WIDTH > 1) ? $clog2(SCREEN_WIDTH) : 1;
    localparam int PAGE_W = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam logic [8:0]        SW_L     = 9'(SCREEN_WIDTH);
    localparam logic [8:0]        SH_L     = 9'(SCREEN_HEIGHT);
    localparam logic [5:0]        PC_L     = 6'(PAGE_COUNT);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    // Request decode (combinational, captured on load)
    logic [8:0] col_sum;
    logic [5:0] page_sum;
    logic [8:0] row_end;
    logic       main_clip;
    logic       lower_needed;
    logic       lower_clip;
    logic       read_ok;
    logic [5:0] page_in;
    logic [8:0] col_in;

    always_comb
    begin
        col_sum      = 9'(left_x) + 9'(image_column);
        page_sum     = 6'(image_page) + 6'(top_y[pfb_pkg::TOP_Y_W-1:3]);
        row_end      = {3'b000, image_page, 3'b000} + 9'(top_y) + pfb_pkg::PAGE_ROWS;
        main_clip    = (col_sum >= SW_L) || (page_sum >= PC_L);
        lower_needed = (top_y[2:0] != 3'd0) && (row_end < SH_L);
        lower_clip   = (page_sum + 6'd1) >= PC_L;
        read_ok      = (6'(read_page) < PC_L) && (9'(read_column) < SW_L);
        page_in      = (mode == pfb_pkg::MODE_READ) ? 6'(read_page) : page_sum;
        col_in       = (mode == pfb_pkg::MODE_READ) ? 9'(read_column) : col_sum;
    end

    // Latched item
    logic [PAGE_W-1:0]         page_reg;
    logic [COL_W-1:0]          col_reg;
    logic [2:0]                shift_reg;
    logic [pfb_pkg::BYTE_W-1:0] pbyte_reg;
    logic                      is_read_reg;
    logic                      go_main_reg;
    logic                      go_lower_reg;
    logic                      clip_reg;
    logic                      written_reg;

    // Frame store and its read register
    logic [pfb_pkg::BYTE_W-1:0] mem [DEPTH];
    logic [pfb_pkg::BYTE_W-1:0] q_reg;
    logic [ADDR_W-1:0]          clr_addr_reg;

    // Shifted byte and masks: low half is the target page, high half the next
    logic [15:0]               bits16;
    logic [15:0]               mask16;
    logic [pfb_pkg::BYTE_W-1:0] bits;
    logic [pfb_pkg::BYTE_W-1:0] keep;
    logic [pfb_pkg::BYTE_W-1:0] merged;
    logic [PAGE_W-1:0]         page_sel;
    logic [AW1-1:0]            addr_full;
    logic [ADDR_W-1:0]         mem_addr;
    logic [pfb_pkg::BYTE_W-1:0] mem_wdata;
    logic                      mem_en;
    logic                      mem_we;

    always_comb
    begin
        bits16    = {8'h00, pbyte_reg} << shift_reg;
        mask16    = {8'h00, pfb_pkg::BYTE_MASK} << shift_reg;
        bits      = cmd.sel_lower ? bits16[15:8] : bits16[7:0];
        keep      = cmd.sel_lower ? ~mask16[15:8] : ~mask16[7:0];
        merged    = (q_reg & keep) | bits;
        page_sel  = cmd.sel_lower ? (page_reg + PAGE_W'(1)) : page_reg;
        addr_full = AW1'(page_sel) * AW1'(SCREEN_WIDTH) + AW1'(col_reg);
        mem_addr  = cmd.clr_step ? clr_addr_reg : addr_full[ADDR_W-1:0];
        mem_wdata = cmd.clr_step ? '0 : merged;
        mem_en    = cmd.clr_step | cmd.mem_rd | cmd.mem_wr;
        mem_we    = cmd.clr_step | cmd.mem_wr;
    end

    // Memory: one access per cycle, registered read
    always_ff @(posedge clk)
    begin
        if (mem_en)
        begin
            if (mem_we)
                mem[mem_addr] <= mem_wdata;
            else
                q_reg <= mem[mem_addr];
        end
    end

    // Clear pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_addr_reg <= '0;
        else if (cmd.clr_step && clr_addr_reg != LAST_ADDR)
            clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
    end

    // Item latch and change tracking
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            page_reg     <= page_in[PAGE_W-1:0];
            col_reg      <= col_in[COL_W-1:0];
            shift_reg    <= top_y[2:0];
            pbyte_reg    <= pixel_byte;
            is_read_reg  <= (mode == pfb_pkg::MODE_READ);
            go_main_reg  <= (mode == pfb_pkg::MODE_READ) ? read_ok : !main_clip;
            go_lower_reg <= !main_clip && lower_needed && !lower_clip;
            clip_reg     <= main_clip || (lower_needed && lower_clip);
            written_reg  <= 1'b0;
        end
        else if (cmd.mem_wr && merged != q_reg)
        begin
            written_reg <= 1'b1;
        end
    end

    // Response register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            read_data <= (is_read_reg && go_main_reg) ? q_reg : '0;
            written   <= !is_read_reg && written_reg;
            clipped   <= !is_read_reg && clip_reg;
        end
    end

    assign status.is_read    = is_read_reg;
    assign status.go_main    = go_main_reg;
    assign status.go_lower   = go_lower_reg;
    assign status.clear_done = (clr_addr_reg == LAST_ADDR);

endmodule

FILE: hw/rtl/page_framebuffer_blitter.sv
// Top level of the monochrome page framebuffer blitter.
// Depends on pfb_pkg, pfb_if, pfb_ctrl and pfb_datapath.
//
// Usage:
//   req  - request beats. mode blit places pixel_byte at image position
//          (image_column, image_page) of an image whose top-left pixel is
//          (left_x, top_y); mode read fetches the byte at
//          (read_page, read_column).
//   rsp  - one response beat per request: read_data for reads, written
//          and clipped flags for blits.
// Sequence: a read or a clipped blit goes from RD_UP straight to FINISH; a
//   one-page blit adds WR_UP, a two-page blit WR_UP, RD_LO and WR_LO. The
//   next request is taken only back in IDLE, after FINISH loads the response
//   register, so items do not overlap; the pace is set by the single-port
//   frame store: one read, and for a blit one write, per page byte touched.
// Reset: a pass zeroes all PAGE_COUNT * SCREEN_WIDTH bytes of the frame store,
//   one byte per cycle; req.ready stays low until it completes.
// Stall: a finished response waits in an output register; the next request
//   is still accepted and processed, and only its response hand-off waits
//   until rsp.ready takes the pending beat.
module page_framebuffer_blitter #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64,
    parameter int PAGE_COUNT    = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    pfb_req_if.sink    req,
    pfb_rsp_if.source  rsp
);

    pfb_pkg::ctrl_cmd_t  cmd;
    pfb_pkg::dp_status_t status;

    // Sequencer
    pfb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Frame store and arithmetic
    pfb_datapath #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .PAGE_COUNT    (PAGE_COUNT)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .mode         (req.mode),
        .left_x       (req.left_x),
        .top_y        (req.top_y),
        .image_column (req.image_column),
        .image_page   (req.image_page),
        .pixel_byte   (req.pixel_byte),
        .read_page    (req.read_page),
        .read_column  (req.read_column),
        .read_data    (rsp.read_data),
        .written      (rsp.written),
        .clipped      (rsp.clipped)
    );

endmodule
